@@ sv/timed_dual_motor_drive_with_interlock_top_assert.svh @@
// ----------------------------------------------------------------------------
// tdmd assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TIMED_DUAL_MOTOR_DRIVE_WITH_INTERLOCK_TOP_ASSERT_SVH
`define TIMED_DUAL_MOTOR_DRIVE_WITH_INTERLOCK_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// consequent holds in the same cycle as the antecedent
`define TDMD_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tdmd: same-cycle check failed");
// consequent holds in the cycle after the antecedent
`define TDMD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tdmd: next-cycle check failed");
`else
`define TDMD_ASSERT_SAME(lbl, ante, cons)
`define TDMD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/tdmd_pkg.sv @@
// ----------------------------------------------------------------------------
// tdmd package
// Types and constants of the timed dual motor drive with interlock.
// ----------------------------------------------------------------------------
package tdmd_pkg;

   // bridge action codes
   typedef enum logic [1:0] {
      ACT_FWD   = 2'd0,
      ACT_REV   = 2'd1,
      ACT_BRAKE = 2'd2,
      ACT_COAST = 2'd3
   } action_type;

   // item kinds
   localparam logic MODE_CMD  = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   // csr register indexes
   localparam logic CSR_HALT_ON_IMPACT   = 1'b0;
   localparam logic CSR_HALT_ON_OBSTACLE = 1'b1;

   localparam int unsigned TimeW = 14;
   localparam logic [TimeW-1:0] DURATION_MAX = 14'd9999;

   // input word
   typedef struct packed {
      logic             mode;
      logic [1:0]       left_action;
      logic [1:0]       right_action;
      logic [TimeW-1:0] duration_ms;
      logic             sound_hit;
      logic             impact_front;
      logic             impact_back;
      logic             obstacle_front;
      logic             obstacle_left;
      logic             obstacle_right;
      logic             obstacle_back;
   } req_word_type;

   // result word
   typedef struct packed {
      logic             left_fwd_pin;
      logic             left_rev_pin;
      logic             right_fwd_pin;
      logic             right_rev_pin;
      logic [TimeW-1:0] time_left;
      logic             finished;
      logic             stopped_by_sensor;
   } rsp_word_type;

   // register write bundle
   typedef struct packed {
      logic we;
      logic index;
      logic wdata;
   } csr_write_type;

endpackage

@@ sv/tdmd_if.sv @@
// ----------------------------------------------------------------------------
// tdmd channel interfaces
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface tdmd_req_if;
   import tdmd_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface tdmd_rsp_if;
   import tdmd_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

@@ sv/tdmd_core.sv @@
// ----------------------------------------------------------------------------
// tdmd core
// Holds the motor actions, countdown, halt flag and csr bits; computes the
// next state and the result word for each accepted request word.
// ----------------------------------------------------------------------------
`include "timed_dual_motor_drive_with_interlock_top_assert.svh"

module tdmd_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  tdmd_pkg::req_word_type req_word,
   input  tdmd_pkg::csr_write_type csr,
   output tdmd_pkg::rsp_word_type rsp_word
);
   import tdmd_pkg::*;

   action_type       left_mode_ff, left_mode_in;
   action_type       right_mode_ff, right_mode_in;
   logic [TimeW-1:0] countdown_ff, countdown_in;
   logic             halted_ff, halted_in;
   logic             halt_on_impact_ff;
   logic             halt_on_obstacle_ff;

   logic [TimeW-1:0] duration_sat;
   logic             any_fwd;
   logic             any_rev;
   logic             sensor_halt;

   // sensor interlock, direction of travel from the current actions
   always_comb begin
      any_fwd = (left_mode_ff == ACT_FWD) || (right_mode_ff == ACT_FWD);
      any_rev = (left_mode_ff == ACT_REV) || (right_mode_ff == ACT_REV);
      sensor_halt = req_word.sound_hit
         || (halt_on_impact_ff && req_word.impact_front && any_fwd)
         || (halt_on_impact_ff && req_word.impact_back && any_rev)
         || (halt_on_obstacle_ff && (left_mode_ff == ACT_FWD)
             && (req_word.obstacle_front || req_word.obstacle_right))
         || (halt_on_obstacle_ff && (right_mode_ff == ACT_FWD)
             && (req_word.obstacle_front || req_word.obstacle_left))
         || (halt_on_obstacle_ff && any_rev && req_word.obstacle_back);
   end

   // next state
   always_comb begin
      duration_sat  = (req_word.duration_ms > DURATION_MAX) ? DURATION_MAX
                                                             : req_word.duration_ms;
      left_mode_in  = left_mode_ff;
      right_mode_in = right_mode_ff;
      countdown_in  = countdown_ff;
      halted_in     = halted_ff;
      if (req_word.mode == MODE_CMD) begin
         left_mode_in  = action_type'(req_word.left_action);
         right_mode_in = action_type'(req_word.right_action);
         countdown_in  = duration_sat;
         halted_in     = 1'b0;
      end else if ((countdown_ff != '0) && !halted_ff) begin
         if (sensor_halt) begin
            halted_in = 1'b1;
         end else begin
            countdown_in = countdown_ff - TimeW'(1);
         end
      end
   end

   // result word from the state after this word
   always_comb begin
      rsp_word.left_fwd_pin      = (left_mode_in == ACT_FWD) || (left_mode_in == ACT_BRAKE);
      rsp_word.left_rev_pin      = (left_mode_in == ACT_REV) || (left_mode_in == ACT_BRAKE);
      rsp_word.right_fwd_pin     = (right_mode_in == ACT_FWD) || (right_mode_in == ACT_BRAKE);
      rsp_word.right_rev_pin     = (right_mode_in == ACT_REV) || (right_mode_in == ACT_BRAKE);
      rsp_word.time_left         = countdown_in;
      rsp_word.finished          = (countdown_in == '0);
      rsp_word.stopped_by_sensor = halted_in;
   end

   // state and csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         left_mode_ff        <= ACT_COAST;
         right_mode_ff       <= ACT_COAST;
         countdown_ff        <= '0;
         halted_ff           <= 1'b0;
         halt_on_impact_ff   <= 1'b1;
         halt_on_obstacle_ff <= 1'b1;
      end else begin
         if (accept) begin
            left_mode_ff  <= left_mode_in;
            right_mode_ff <= right_mode_in;
            countdown_ff  <= countdown_in;
            halted_ff     <= halted_in;
         end
         if (csr.we) begin
            case (csr.index)
               CSR_HALT_ON_IMPACT:   halt_on_impact_ff   <= csr.wdata;
               CSR_HALT_ON_OBSTACLE: halt_on_obstacle_ff <= csr.wdata;
               default: ;
            endcase
         end
      end
   end

   // checks
   `TDMD_ASSERT_SAME(a_count_in_range, 1'b1, countdown_ff <= DURATION_MAX)
   `TDMD_ASSERT_NEXT(a_halt_freezes, accept && (req_word.mode == MODE_TICK) && halted_ff,
                     $stable(countdown_ff) && halted_ff)
   `TDMD_ASSERT_NEXT(a_cmd_clears_halt, accept && (req_word.mode == MODE_CMD), !halted_ff)

endmodule

@@ sv/tdmd_out_buf.sv @@
// ----------------------------------------------------------------------------
// tdmd output buffer
// Result register plus one skid entry, so a word is taken while the
// previous result still waits on the result channel.
// ----------------------------------------------------------------------------
`include "timed_dual_motor_drive_with_interlock_top_assert.svh"

module tdmd_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  tdmd_pkg::rsp_word_type in_word,
   output logic                   out_valid,
   input  logic                   out_ready,
   output tdmd_pkg::rsp_word_type out_word
);
   import tdmd_pkg::*;

   logic         main_valid_ff;
   rsp_word_type main_word_ff;
   logic         skid_valid_ff;
   rsp_word_type skid_word_ff;
   logic         push;
   logic         pop;

   assign in_ready  = !skid_valid_ff;
   assign push      = in_valid && in_ready;
   assign pop       = main_valid_ff && out_ready;
   assign out_valid = main_valid_ff;
   assign out_word  = main_word_ff;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= push;
         end
      end else if (push) begin
         if (main_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (pop) begin
         if (skid_valid_ff) begin
            main_word_ff <= skid_word_ff;
         end else if (push) begin
            main_word_ff <= in_word;
         end
      end else if (push) begin
         if (main_valid_ff) begin
            skid_word_ff <= in_word;
         end else begin
            main_word_ff <= in_word;
         end
      end
   end

   // checks
   `TDMD_ASSERT_SAME(a_skid_behind_main, skid_valid_ff, main_valid_ff)
   `TDMD_ASSERT_NEXT(a_skid_to_main, pop && skid_valid_ff,
                     main_valid_ff && (main_word_ff == $past(skid_word_ff)))
   `TDMD_ASSERT_NEXT(a_fill_skid, push && main_valid_ff && !out_ready, skid_valid_ff)

endmodule

@@ sv/timed_dual_motor_drive_with_interlock_top.sv @@
// ----------------------------------------------------------------------------
// timed dual motor drive with interlock, top level
// Command words set both bridge actions and a millisecond duration; tick
// words count it down unless a sensor interlock halts the motion.
// ----------------------------------------------------------------------------
// One request word is taken every clock cycle unless stalled and gives one
// registered result word. The work per word is one saturate, one sensor
// check and one 14-bit decrement between the state registers and the
// result register. A two-entry output buffer keeps the request side open
// for one word while a result stalls; the request side stalls only when
// both entries hold results. Csr writes take effect at the next edge and
// belong in idle periods.
// ----------------------------------------------------------------------------
module timed_dual_motor_drive_with_interlock_top (
   input  logic        clock,
   input  logic        reset,
   tdmd_req_if.sink    req_ch,
   tdmd_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic        csr_wdata
);
   import tdmd_pkg::*;

   logic          accept;
   logic          buf_ready;
   rsp_word_type  next_word;
   csr_write_type csr;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   assign req_ch.ready = buf_ready;
   assign accept       = req_ch.valid && buf_ready;

   // state and next-state logic
   tdmd_core u_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_word (req_ch.word),
      .csr      (csr),
      .rsp_word (next_word)
   );

   // result register and skid entry
   tdmd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (buf_ready),
      .in_word   (next_word),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_word  (rsp_ch.word)
   );

endmodule

@@ bench/timed_dual_motor_drive_with_interlock_top_test.sv @@
// ----------------------------------------------------------------------------
// timed dual motor drive with interlock, testbench
// Feeds command and tick words through the request channel, predicts each
// result word from a local model of the drive state and the interlock rules,
// and checks every result word field by field. Runs four interlock settings
// with changing idle patterns and long result-side stalls.
// ----------------------------------------------------------------------------
module timed_dual_motor_drive_with_interlock_top_test;
   import tdmd_pkg::*;

   // sensor flag masks, in the order sound, impact f/b, obstacle f/l/r/b
   localparam logic [6:0] SENSE_NONE         = 7'b000_0000;
   localparam logic [6:0] SENSE_SOUND        = 7'b100_0000;
   localparam logic [6:0] SENSE_IMPACT_FRONT = 7'b010_0000;
   localparam logic [6:0] SENSE_IMPACT_BACK  = 7'b001_0000;
   localparam logic [6:0] SENSE_OBS_FRONT    = 7'b000_1000;
   localparam logic [6:0] SENSE_OBS_LEFT     = 7'b000_0100;
   localparam logic [6:0] SENSE_OBS_RIGHT    = 7'b000_0010;
   localparam logic [6:0] SENSE_OBS_BACK     = 7'b000_0001;

   localparam int RandomRunWords = 380;
   localparam int StallCycles    = 60;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_index;
   logic csr_wdata;

   tdmd_req_if req_bus ();
   tdmd_rsp_if rsp_bus ();

   timed_dual_motor_drive_with_interlock_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // words waiting to be offered and results waiting to arrive
   req_word_type pending_words[$];
   rsp_word_type expected_results[$];

   int words_queued  = 0;
   int words_checked = 0;
   int failures      = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_requests = 0;
   int stalls_started = 0;
   int stall_left     = 0;

   // local copy of the drive state and the interlock enables
   action_type       drive_left    = ACT_COAST;
   action_type       drive_right   = ACT_COAST;
   logic [TimeW-1:0] ms_remaining  = '0;
   logic             sensor_halted = 1'b0;
   logic             cfg_impact    = 1'b1;
   logic             cfg_obstacle  = 1'b1;

   // clock
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // interlock rules, in priority order
   function automatic logic interlock_trips(req_word_type w);
      logic any_fwd;
      logic any_rev;
      any_fwd = (drive_left == ACT_FWD) || (drive_right == ACT_FWD);
      any_rev = (drive_left == ACT_REV) || (drive_right == ACT_REV);
      if (w.sound_hit)
         return 1'b1;
      if (cfg_impact && w.impact_front && any_fwd)
         return 1'b1;
      if (cfg_impact && w.impact_back && any_rev)
         return 1'b1;
      if (cfg_obstacle && drive_left == ACT_FWD && (w.obstacle_front || w.obstacle_right))
         return 1'b1;
      if (cfg_obstacle && drive_right == ACT_FWD && (w.obstacle_front || w.obstacle_left))
         return 1'b1;
      if (cfg_obstacle && any_rev && w.obstacle_back)
         return 1'b1;
      return 1'b0;
   endfunction

   // advance the drive model by one accepted word and queue its result
   function automatic void predict_drive(req_word_type w);
      rsp_word_type r;
      if (w.mode == MODE_CMD) begin
         drive_left    = action_type'(w.left_action);
         drive_right   = action_type'(w.right_action);
         ms_remaining  = (w.duration_ms > DURATION_MAX) ? DURATION_MAX : w.duration_ms;
         sensor_halted = 1'b0;
      end else if (ms_remaining != 0 && !sensor_halted) begin
         if (interlock_trips(w))
            sensor_halted = 1'b1;
         else
            ms_remaining = ms_remaining - TimeW'(1);
      end
      r.left_fwd_pin      = (drive_left == ACT_FWD) || (drive_left == ACT_BRAKE);
      r.left_rev_pin      = (drive_left == ACT_REV) || (drive_left == ACT_BRAKE);
      r.right_fwd_pin     = (drive_right == ACT_FWD) || (drive_right == ACT_BRAKE);
      r.right_rev_pin     = (drive_right == ACT_REV) || (drive_right == ACT_BRAKE);
      r.time_left         = ms_remaining;
      r.finished          = (ms_remaining == 0);
      r.stopped_by_sensor = sensor_halted;
      expected_results.push_back(r);
   endfunction

   function automatic void check_field(string name, logic [TimeW-1:0] want,
                                       logic [TimeW-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   // word builders; fields the block ignores get random content
   function automatic req_word_type random_word();
      logic [31:0] bits;
      bits = $urandom;
      return bits[$bits(req_word_type)-1:0];
   endfunction

   function automatic req_word_type command_word(action_type l, action_type r,
                                                 logic [TimeW-1:0] dur);
      req_word_type w;
      w              = random_word();
      w.mode         = MODE_CMD;
      w.left_action  = l;
      w.right_action = r;
      w.duration_ms  = dur;
      return w;
   endfunction

   function automatic req_word_type tick_word(logic [6:0] sensors);
      req_word_type w;
      w      = random_word();
      w.mode = MODE_TICK;
      {w.sound_hit, w.impact_front, w.impact_back, w.obstacle_front,
       w.obstacle_left, w.obstacle_right, w.obstacle_back} = sensors;
      return w;
   endfunction

   function automatic void queue_word(req_word_type w);
      pending_words.push_back(w);
      words_queued++;
   endfunction

   // driver: offer pending words, predict on each accepted word
   always @(posedge clock) begin : feed
      req_word_type next_word;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_bus.valid)
            predict_drive(req_bus.word);
         if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_word = pending_words.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.word  <= next_word;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // monitor: check accepted results, random and long stalls on ready
   always @(posedge clock) begin : watch
      rsp_word_type want;
      rsp_word_type got;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = rsp_bus.word;
            if (expected_results.size() == 0) begin
               $error("result word with nothing expected");
               failures++;
            end else begin
               want = expected_results.pop_front();
               check_field("left_fwd_pin", want.left_fwd_pin, got.left_fwd_pin);
               check_field("left_rev_pin", want.left_rev_pin, got.left_rev_pin);
               check_field("right_fwd_pin", want.right_fwd_pin, got.right_fwd_pin);
               check_field("right_rev_pin", want.right_rev_pin, got.right_rev_pin);
               check_field("time_left", want.time_left, got.time_left);
               check_field("finished", want.finished, got.finished);
               check_field("stopped_by_sensor", want.stopped_by_sensor,
                           got.stopped_by_sensor);
               words_checked++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stalls_started != stall_requests) begin
            stalls_started = stall_requests;
            stall_left     = StallCycles;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // wait until every queued word has produced its checked result
   task automatic settle();
      while (words_checked != words_queued)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_HALT_ON_IMPACT)
         cfg_impact = val;
      else
         cfg_obstacle = val;
   endtask

   function automatic logic [6:0] random_sensors(int pct);
      logic [6:0] s;
      for (int b = 0; b < 7; b++)
         s[b] = ($urandom_range(99) < pct);
      return s;
   endfunction

   // mostly command-then-ticks runs with random content, some noise words
   task automatic queue_random_run(int count);
      int added;
      int pick;
      int ticks;
      logic [TimeW-1:0] dur;
      added = 0;
      while (added < count) begin
         if ($urandom_range(99) < 80) begin
            pick = $urandom_range(99);
            if (pick < 70)
               dur = TimeW'($urandom_range(1, 12));
            else if (pick < 80)
               dur = '0;
            else if (pick < 90)
               dur = TimeW'($urandom_range(9990, 16383));
            else
               dur = TimeW'($urandom_range(0, 9999));
            queue_word(command_word(action_type'($urandom_range(3)),
                                    action_type'($urandom_range(3)), dur));
            ticks = (dur <= 12) ? dur + $urandom_range(0, 3) : $urandom_range(1, 8);
            for (int t = 0; t < ticks; t++)
               queue_word(tick_word(random_sensors(6)));
            added += ticks + 1;
         end else begin
            queue_word(random_word());
            added++;
         end
      end
   endtask

   // stimulus and phases
   initial begin
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = CSR_HALT_ON_IMPACT;
      csr_wdata     = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.word  = '0;
      rsp_bus.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // both interlocks on, as after reset
      send_idle_pct = 29;
      recv_idle_pct = 88;
      queue_word(command_word(ACT_FWD, ACT_FWD, 14'd3));
      queue_word(tick_word(SENSE_NONE));
      queue_word(tick_word(SENSE_IMPACT_BACK));       // no reverse motor
      queue_word(tick_word(SENSE_OBS_BACK));          // runs out here
      queue_word(tick_word(SENSE_SOUND));             // tick after the end
      queue_word(command_word(ACT_REV, ACT_REV, 14'd5));
      queue_word(tick_word(SENSE_IMPACT_FRONT));      // no forward motor
      queue_word(tick_word(SENSE_IMPACT_BACK));       // halts
      queue_word(tick_word(SENSE_NONE));              // frozen while halted
      queue_word(command_word(ACT_BRAKE, ACT_COAST, 14'd0));
      queue_word(tick_word(SENSE_SOUND));             // zero duration
      queue_word(command_word(ACT_COAST, ACT_FWD, 14'd16383));
      queue_word(tick_word(SENSE_OBS_RIGHT));         // right side irrelevant
      queue_word(tick_word(SENSE_OBS_LEFT));          // halts
      queue_word(command_word(ACT_FWD, ACT_COAST, 14'd9999));
      queue_word(tick_word(SENSE_OBS_LEFT));
      queue_word(tick_word(SENSE_OBS_RIGHT));         // halts
      queue_word(command_word(ACT_FWD, ACT_REV, 14'd10000));
      queue_word(tick_word(SENSE_OBS_BACK));          // halts
      queue_word(command_word(ACT_REV, ACT_FWD, 14'd2));
      queue_word(tick_word(SENSE_OBS_FRONT));         // halts
      queue_word(command_word(ACT_FWD, ACT_BRAKE, 14'd4));
      queue_word(tick_word(SENSE_IMPACT_FRONT));      // halts
      queue_word(command_word(ACT_BRAKE, ACT_BRAKE, 14'd1));
      queue_word(tick_word(7'b011_1111));             // brakes ignore sensors
      queue_word(tick_word(SENSE_NONE));
      queue_word(command_word(ACT_COAST, ACT_COAST, 14'd2));
      queue_word(tick_word(SENSE_SOUND));
      queue_random_run(RandomRunWords);
      stall_requests++;
      settle();

      // both interlocks off
      write_csr(CSR_HALT_ON_IMPACT, 1'b0);
      write_csr(CSR_HALT_ON_OBSTACLE, 1'b0);
      send_idle_pct = 88;
      recv_idle_pct = 29;
      queue_random_run(RandomRunWords);
      settle();

      // impact only, no idling
      write_csr(CSR_HALT_ON_IMPACT, 1'b1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random_run(RandomRunWords);
      stall_requests++;
      settle();

      // obstacle only
      write_csr(CSR_HALT_ON_IMPACT, 1'b0);
      write_csr(CSR_HALT_ON_OBSTACLE, 1'b1);
      queue_random_run(RandomRunWords);
      settle();

      repeat (5) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d result words never arrived", expected_results.size());
         failures++;
      end
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
